### design/hashed_pattern_histogram_assert.svh
// Assertion macros for the hashed pattern histogram.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef HASHED_PATTERN_HISTOGRAM_ASSERT_SVH
`define HASHED_PATTERN_HISTOGRAM_ASSERT_SVH
// Checked property, off while reset is low.
`define HPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked property, also evaluated across reset.
`define HPH_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

### design/hph_pkg.sv
// Shared constants, codes and types of the hashed pattern histogram.
// No dependencies; every design module and interface imports it.
package hph_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int DENSE_WIDTH = 10;
    localparam int KEY_W       = 32;
    localparam int CNT_W       = 64;
    localparam int DIST_W      = $clog2(TABLE_DEPTH + 1);
    localparam int WID_W       = 6;
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D049BB133111EB;
    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
    localparam logic [DIST_W-1:0] DIST_MAX   = DIST_W'(TABLE_DEPTH);
    // A new key is refused once distinct + 1 would exceed three quarters.
    localparam logic [DIST_W-1:0] FULL_LIMIT = DIST_W'(TABLE_DEPTH * 3 / 4);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0, ACT_RD_SLOT = 2'd1, ACT_RD_SENT = 2'd2, ACT_NOP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NEW = 2'd1, ST_FULL = 2'd2, ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        K_DENSE_ADD, K_HASH_ADD, K_SENT_ADD, K_ADD_RANGE, K_DENSE_RD,
        K_HASH_RD, K_SENT_RD, K_SENT_DENSE, K_RD_RANGE, K_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   gamma;
        logic [CNT_W-1:0]   weight;
        logic [SLOT_W-1:0]  slot;
    } t_entry;

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} t_front_state;
    typedef enum logic [0:0] {B_IDLE, B_EVAL} t_back_state;

    // Mode as seen by the front end.
    typedef struct packed {
        logic             dense;
        logic [WID_W-1:0] eff_width;
        logic             clearing;
    } t_mode;
endpackage

### design/hph_if.sv
// Valid/ready channel interfaces for items and results.
// Depends on hph_pkg.
interface hph_in_if import hph_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [KEY_W-1:0]  gamma;
    logic [CNT_W-1:0]  weight;
    logic [SLOT_W-1:0] slot_index;
    modport source(output valid, action, gamma, weight, slot_index, input ready);
    modport sink(input valid, action, gamma, weight, slot_index, output ready);
endinterface

interface hph_out_if import hph_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [KEY_W-1:0]  slot_key;
    logic [CNT_W-1:0]  slot_count;
    logic              occupied;
    logic [DIST_W-1:0] distinct_patterns;
    logic [CNT_W-1:0]  total_weight;
    modport source(output valid, status, slot_key, slot_count, occupied,
                   distinct_patterns, total_weight, input ready);
    modport sink(input valid, status, slot_key, slot_count, occupied,
                 distinct_patterns, total_weight, output ready);
endinterface

### design/hph_front.sv
// Front end: accepts items, classifies them and hashes keys for hash mode.
// Depends on hph_pkg and hph_if.
module hph_front import hph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mode       i_mode,
    hph_in_if.sink      i_item,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);
    t_front_state r_state, n_state;
    logic [3:0]   r_step;
    logic [63:0]  r_x, r_acc;
    t_entry       r_entry;
    logic         accept;
    t_kind        kind;
    logic [63:0]  x0, mul_c, h;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;

    assign i_item.ready = (r_state == F_IDLE) && !i_mode.clearing;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        kind = K_NOP;
        case (t_action'(i_item.action))
            ACT_ADD: begin
                if (i_mode.dense) begin
                    kind = ((i_item.gamma >> i_mode.eff_width) != '0) ? K_ADD_RANGE
                                                                      : K_DENSE_ADD;
                end else begin
                    kind = (i_item.gamma == EMPTY_KEY) ? K_SENT_ADD : K_HASH_ADD;
                end
            end
            ACT_RD_SLOT: begin
                if (i_mode.dense) begin
                    kind = ((i_item.slot_index >> i_mode.eff_width) != '0) ? K_RD_RANGE
                                                                           : K_DENSE_RD;
                end else begin
                    kind = K_HASH_RD;
                end
            end
            ACT_RD_SENT: kind = i_mode.dense ? K_SENT_DENSE : K_SENT_RD;
            default:     kind = K_NOP;
        endcase
    end

    // One 32x32 multiplier, three partial products per 64-bit multiply.
    always_comb begin
        x0    = {32'd0, i_item.gamma} + SM_GAMMA;
        mul_c = r_step[2] ? SM_MUL2 : SM_MUL1;
        case (r_step[1:0])
            2'd2:    begin mul_a = r_x[63:32]; mul_b = mul_c[31:0];  end
            2'd3:    begin mul_a = r_x[31:0];  mul_b = mul_c[63:32]; end
            default: begin mul_a = r_x[31:0];  mul_b = mul_c[31:0];  end
        endcase
        prod = {32'd0, mul_a} * {32'd0, mul_b};
        h    = r_acc ^ (r_acc >> 31);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) n_state = (kind == K_HASH_ADD) ? F_HASH : F_PUSH;
            end
            F_HASH: if (r_step == 4'd8) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_push  = (r_state == F_PUSH) && !i_full;
        o_entry = r_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= 4'd1;
        end else begin
            r_state <= n_state;
            if (accept) r_step <= 4'd1;
            else if (r_state == F_HASH) r_step <= r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.kind   <= kind;
            r_entry.gamma  <= i_item.gamma;
            r_entry.weight <= i_item.weight;
            r_entry.slot   <= (t_action'(i_item.action) == ACT_ADD) ?
                              i_item.gamma[SLOT_W-1:0] : i_item.slot_index;
            r_x            <= x0 ^ (x0 >> 30);
        end else if (r_state == F_HASH) begin
            case (r_step[1:0])
                2'd1:    r_acc <= prod;
                2'd0:    r_x   <= r_acc ^ (r_acc >> 27);
                default: r_acc <= r_acc + {prod[31:0], 32'd0};
            endcase
            if (r_step == 4'd8) r_entry.slot <= h[32 +: SLOT_W];
        end
    end
endmodule

### design/hph_fifo.sv
// Short queue between the front end and the back end.
// Depends on hph_pkg.
module hph_fifo import hph_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_full,
    output logic   o_empty
);
    t_entry              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]   r_wr, r_rd;
    logic [FPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (FPTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (FPTR_W+1)'(i_push) - (FPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end
endmodule

### design/hph_back.sv
// Back end: owns the key and count memories, probes, updates and delivers results.
// Depends on hph_pkg and hph_if.
module hph_back import hph_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_clear,
    input  t_entry  i_head,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_clearing,
    hph_out_if.source o_result
);
    logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
    logic [CNT_W-1:0]  cnt_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  r_rkey;
    logic [CNT_W-1:0]  r_rcnt;

    t_back_state       r_state, n_state;
    t_entry            r_cur;
    logic [SLOT_W-1:0] r_addr, n_addr, r_clr_addr;
    logic              r_clearing;
    logic [DIST_W-1:0] r_distinct, n_distinct;
    logic [CNT_W-1:0]  r_total, n_total, r_sent_total, n_sent_total;
    logic              r_sent_present, n_sent_present;

    logic              r_out_valid;
    t_status           r_status, res_status;
    logic [KEY_W-1:0]  r_key, res_key;
    logic [CNT_W-1:0]  r_cnt, res_cnt;
    logic              r_occ, res_occ;
    logic              res_load, go, mem_kind;

    logic [SLOT_W-1:0] mem_raddr, mem_waddr;
    logic              key_we, cnt_we;
    logic [KEY_W-1:0]  wkey;
    logic [CNT_W-1:0]  wcnt, sum;
    logic [DIST_W-1:0] dist_inc;

    assign o_clearing = r_clearing;
    assign go = (r_state == B_IDLE) && !r_clearing && !i_empty && !r_out_valid;
    assign mem_kind = (i_head.kind == K_DENSE_ADD) || (i_head.kind == K_HASH_ADD) ||
                      (i_head.kind == K_DENSE_RD) || (i_head.kind == K_HASH_RD);
    assign sum      = r_rcnt + r_cur.weight;
    assign dist_inc = (r_distinct < DIST_MAX) ? r_distinct + 1'b1 : r_distinct;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (go && mem_kind) n_state = B_EVAL;
            B_EVAL:  if (res_load) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = 1'b0;
        res_load       = 1'b0;
        res_status     = ST_OK;
        res_key        = '0;
        res_cnt        = '0;
        res_occ        = 1'b0;
        n_addr         = r_addr;
        n_distinct     = r_distinct;
        n_total        = r_total;
        n_sent_total   = r_sent_total;
        n_sent_present = r_sent_present;
        mem_raddr      = r_addr;
        mem_waddr      = r_addr;
        key_we         = 1'b0;
        cnt_we         = 1'b0;
        wkey           = r_cur.gamma;
        wcnt           = sum;
        if (r_clearing) begin
            key_we    = 1'b1;
            cnt_we    = 1'b1;
            mem_waddr = r_clr_addr;
            wkey      = EMPTY_KEY;
            wcnt      = '0;
        end else if (go) begin
            o_pop     = 1'b1;
            mem_raddr = i_head.slot;
            n_addr    = i_head.slot;
            res_load  = !mem_kind;
            case (i_head.kind)
                K_SENT_ADD: begin
                    n_sent_present = 1'b1;
                    if (!r_sent_present) begin
                        n_distinct = dist_inc;
                        res_status = ST_NEW;
                    end
                    n_sent_total = r_sent_total + i_head.weight;
                    n_total      = r_total + i_head.weight;
                    res_key      = i_head.gamma;
                    res_cnt      = n_sent_total;
                    res_occ      = 1'b1;
                end
                K_ADD_RANGE: begin
                    res_status = ST_RANGE;
                    res_key    = i_head.gamma;
                end
                K_SENT_RD: begin
                    res_key = EMPTY_KEY;
                    res_occ = r_sent_present;
                    res_cnt = r_sent_present ? r_sent_total : '0;
                end
                K_SENT_DENSE: res_key = EMPTY_KEY;
                K_RD_RANGE:   res_status = ST_RANGE;
                default: ;
            endcase
        end else if (r_state == B_EVAL) begin
            res_load = 1'b1;
            case (r_cur.kind)
                K_DENSE_ADD: begin
                    cnt_we  = 1'b1;
                    n_total = r_total + r_cur.weight;
                    if (r_rcnt == '0) begin
                        n_distinct = dist_inc;
                        res_status = ST_NEW;
                    end
                    res_key = r_cur.gamma;
                    res_cnt = sum;
                    res_occ = 1'b1;
                end
                K_DENSE_RD: begin
                    res_key = KEY_W'(r_addr);
                    res_cnt = r_rcnt;
                    res_occ = (r_rcnt != '0);
                end
                K_HASH_RD: begin
                    if (r_rkey != EMPTY_KEY) begin
                        res_key = r_rkey;
                        res_cnt = r_rcnt;
                        res_occ = 1'b1;
                    end
                end
                K_HASH_ADD: begin
                    res_key = r_cur.gamma;
                    if (r_rkey == r_cur.gamma) begin
                        cnt_we  = 1'b1;
                        n_total = r_total + r_cur.weight;
                        res_cnt = sum;
                        res_occ = 1'b1;
                    end else if (r_rkey == EMPTY_KEY) begin
                        if (r_distinct >= FULL_LIMIT) begin
                            res_status = ST_FULL;
                        end else begin
                            key_we     = 1'b1;
                            cnt_we     = 1'b1;
                            wcnt       = r_cur.weight;
                            n_distinct = dist_inc;
                            n_total    = r_total + r_cur.weight;
                            res_status = ST_NEW;
                            res_cnt    = r_cur.weight;
                            res_occ    = 1'b1;
                        end
                    end else begin
                        // Collision: step to the next slot and wait for its data.
                        res_load  = 1'b0;
                        n_addr    = r_addr + 1'b1;
                        mem_raddr = n_addr;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[mem_waddr] <= wkey;
        if (cnt_we) cnt_mem[mem_waddr] <= wcnt;
        r_rkey <= key_mem[mem_raddr];
        r_rcnt <= cnt_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state        <= B_IDLE;
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_distinct     <= '0;
            r_total        <= '0;
            r_sent_total   <= '0;
            r_sent_present <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_distinct     <= n_distinct;
            r_total        <= n_total;
            r_sent_total   <= n_sent_total;
            r_sent_present <= n_sent_present;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) r_clearing <= 1'b0;
            end
            if (res_load) r_out_valid <= 1'b1;
            else if (o_result.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_head;
        r_addr <= n_addr;
        if (res_load) begin
            r_status <= res_status;
            r_key    <= res_key;
            r_cnt    <= res_cnt;
            r_occ    <= res_occ;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.status            = r_status;
    assign o_result.slot_key          = r_key;
    assign o_result.slot_count        = r_cnt;
    assign o_result.occupied          = r_occ;
    assign o_result.distinct_patterns = r_distinct;
    assign o_result.total_weight      = r_total;
endmodule

### design/hashed_pattern_histogram.sv
// Top level of the hashed pattern histogram: width register, front end, queue, back end.
// Depends on hph_pkg, hph_if, hph_front, hph_fifo, hph_back and the assertion header.
`include "hashed_pattern_histogram_assert.svh"

// Weighted histogram of 32-bit keys. Each transfer on i_item adds a weight to a
// key, reads a table slot, reads the all-ones sentinel counter or does nothing,
// and yields one result transfer on o_result that also carries the distinct-key
// count and the running weight total. With pattern_width at most ten the key
// addresses the count memory directly; above that the key is hashed (upper half
// of a splitmix64 finalizer) and placed by linear probing, and new keys past
// three quarters load are refused. Flow: the front end takes one transfer at a
// time; an item that needs no hash is registered and pushed into the queue once
// the queue is not full, and a hash-mode add first runs its hash steps through the
// shared 32x32 multiplier. The back end answers items that need no memory from the
// queue head and reads memory items from the slot memory one probed slot at a
// time, limited by its single read port. A clearing pass over all 1024 slots runs
// after reset and after each write of pattern_width; no item is accepted during it.
module hashed_pattern_histogram import hph_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WID_W-1:0] i_cfg_wdata,
    hph_in_if.sink           i_item,
    hph_out_if.source        o_result
);
    logic [WID_W-1:0] r_width;
    logic [WID_W-1:0] eff_width;
    t_mode            mode;
    logic             w_clearing;
    logic             push, pop, full, empty;
    t_entry           push_entry, head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WID_W'(32);
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    // Width zero acts as one bit, anything above 32 as 32 bits.
    always_comb begin
        if (r_width == '0)              eff_width = WID_W'(1);
        else if (r_width > WID_W'(32))  eff_width = WID_W'(32);
        else                            eff_width = r_width;
        mode.dense     = (eff_width <= WID_W'(DENSE_WIDTH));
        mode.eff_width = eff_width;
        mode.clearing  = w_clearing;
    end

    hph_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (mode),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    hph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    hph_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_we),
        .i_head     (head_entry),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_clearing (w_clearing),
        .o_result   (o_result)
    );

    // The memories are being swept, so the input side must hold off.
    `HPH_ASSERT(a_no_accept_clear, w_clearing |-> !i_item.ready, "ready during clearing")
    // A width write must restart the clearing sweep.
    `HPH_ASSERT(a_cfg_clears, i_cfg_we |=> w_clearing, "no clear after width write")
    // The distinct count saturates at the table depth.
    `HPH_ASSERT(a_distinct_bound, o_result.distinct_patterns <= DIST_MAX, "distinct too high")
    // Reset always starts the clearing sweep.
    `HPH_ASSERT_RST(a_reset_clears, !i_rst_n |=> w_clearing, "no clear after reset")
endmodule
